/* hw/rtl/adt_pkg.sv */
// ============================================================================
// adt_pkg
// Shared constants, codes and control types of the aim dip trigger detector.
// ============================================================================
package adt_pkg;

    // Fixed field widths of the configuration registers.
    localparam int HALF_W     = 10;
    localparam int DZ_LO_W    = 10;
    localparam int DZ_HI_W    = 11;
    localparam int DROP_W     = 10;
    localparam int TOL_W      = 10;
    localparam int SDIV_W     = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    // Width of the divisor port of the shared divider.
    localparam int DSOR_W = (HALF_W > SDIV_W) ? HALF_W : SDIV_W;

    // Width of the angle result ports.
    localparam int OUT_ANG_W = 16;

    // Parameter defaults.
    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 8;

    // Angle constants in whole degrees.
    localparam int ANGLE_DEG_LIM  = 90;
    localparam int ANGLE_DEG_NONE = 100;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_RES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE_HI = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN_Y_TOL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN_X_TOL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_DIV   = 3'd7;

    // Register reset values.
    localparam logic [HALF_W-1:0]  HALF_RES_RST     = 10'd240;
    localparam logic [DZ_LO_W-1:0] DEAD_ZONE_LO_RST = 10'd220;
    localparam logic [DZ_HI_W-1:0] DEAD_ZONE_HI_RST = 11'd260;
    localparam logic [DROP_W-1:0]  DROP_MIN_RST     = 10'd24;
    localparam logic [DROP_W-1:0]  DROP_MAX_RST     = 10'd192;
    localparam logic [TOL_W-1:0]   RETURN_Y_TOL_RST = 10'd24;
    localparam logic [TOL_W-1:0]   RETURN_X_TOL_RST = 10'd24;
    localparam logic [SDIV_W-1:0]  SMOOTH_DIV_RST   = 8'd4;

    // Division operations, in the order the controller issues them.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_AX = 2'd0;
    localparam logic [OP_W-1:0] OP_AY = 2'd1;
    localparam logic [OP_W-1:0] OP_SY = 2'd2;
    localparam logic [OP_W-1:0] OP_SX = 2'd3;

    typedef struct packed {
        logic            load_in;
        logic            stroke;
        logic            div_start;
        logic            div_store;
        logic            publish;
        logic [OP_W-1:0] op;
    } adt_cmd_t;

    typedef struct packed {
        logic found;
        logic div_done;
    } adt_sts_t;

endpackage

/* hw/rtl/aim_dip_trigger_detector.sv */
// ============================================================================
// aim_dip_trigger_detector
// Dead zone snap, dip stroke trigger and smoothed angle output for one
// tracked aim point per frame.
// ============================================================================
//
//   channel   direction  handshake                payload
//   --------  ---------  -----------------------  ------------------------------
//   item      in         item_valid/item_stall    found, point_x, point_y
//   result    out        result_valid/result_stall fired, aim_x, aim_y, angle_x,
//                                                 angle_y, smooth_x, smooth_y
//   config    in         cfg_we                   cfg_index, cfg_data
//
// A request with an object runs four divisions on the one-bit-per-cycle
// divider, which serves the two angles and the two smoothing steps in turn;
// a request with no object needs none. One request is worked on at a time.
// Reset clears the stroke state and the averages and loads the register
// defaults. A stalled result waits in the output register while the next
// request is already being worked on.
// ============================================================================
module aim_dip_trigger_detector
    import adt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        found,
    input  logic [COORD_BITS-1:0]       point_x,
    input  logic [COORD_BITS-1:0]       point_y,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        fired,
    output logic [COORD_BITS-1:0]       aim_x,
    output logic [COORD_BITS-1:0]       aim_y,
    output logic signed [OUT_ANG_W-1:0] angle_x,
    output logic signed [OUT_ANG_W-1:0] angle_y,
    output logic signed [OUT_ANG_W-1:0] smooth_x,
    output logic signed [OUT_ANG_W-1:0] smooth_y
);

    adt_cmd_t cmd;
    adt_sts_t sts;

    adt_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    adt_datapath
    #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .found     (found),
        .point_x   (point_x),
        .point_y   (point_y),
        .fired     (fired),
        .aim_x     (aim_x),
        .aim_y     (aim_y),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .smooth_x  (smooth_x),
        .smooth_y  (smooth_y),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTH
    // Once a request is taken, the block is busy with it in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("request taken but block not busy next cycle");

    // The divider only finishes while a request is being worked on.
    a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> item_stall)
        else $error("divider finished while block idle");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> !result_valid || !result_stall)
        else $error("result register overwritten while stalled");
`endif

endmodule

/* hw/rtl/adt_div.sv */
// ============================================================================
// adt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module adt_div
#(
    parameter int DIV_W = 25,
    parameter int DV_W  = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DV_W-1:0]  divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DV_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]  dsor_reg, dsor_next;
    logic [DV_W:0]    trial;
    logic             ge;

    // The quotient register shifts the dividend out at the top while the
    // quotient bits come in at the bottom.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        ge        = (trial >= {1'b0, dsor_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsor_next = dsor_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DV_W'(trial - {1'b0, dsor_reg}) : DV_W'(trial);
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dsor_reg <= dsor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/adt_ctrl.sv */
// ============================================================================
// adt_ctrl
// Sequencer: takes a request, runs the stroke update and four divisions
// when an object is found, then hands the result to the output register.
// ============================================================================
module adt_ctrl
    import adt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    output logic     result_valid,
    input  logic     result_stall,
    output adt_cmd_t cmd,
    input  adt_sts_t sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STROKE = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_PUB    = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cmd.load_in   = 1'b0;
        cmd.stroke    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_store = 1'b0;
        cmd.publish   = 1'b0;
        cmd.op        = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_STROKE;
                end
            end
            S_STROKE:
            begin
                // With no object the state is held and no division is needed.
                if (sts.found)
                begin
                    cmd.stroke = 1'b1;
                    op_next    = OP_AX;
                    state_next = S_START;
                end
                else
                begin
                    state_next = S_PUB;
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    case (op_reg)
                        OP_AX:   op_next = OP_AY;
                        OP_AY:   op_next = OP_SY;
                        OP_SY:   op_next = OP_SX;
                        default: op_next = OP_AX;
                    endcase
                    state_next = (op_reg == OP_SX) ? S_PUB : S_START;
                end
            end
            S_PUB:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_AX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

/* hw/rtl/adt_datapath.sv */
// ============================================================================
// adt_datapath
// Configuration registers, stroke tracking, angle and smoothing arithmetic
// around the shared divider, and the result register.
// ============================================================================
module adt_datapath
    import adt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        found,
    input  logic [COORD_BITS-1:0]       point_x,
    input  logic [COORD_BITS-1:0]       point_y,
    output logic                        fired,
    output logic [COORD_BITS-1:0]       aim_x,
    output logic [COORD_BITS-1:0]       aim_y,
    output logic signed [OUT_ANG_W-1:0] angle_x,
    output logic signed [OUT_ANG_W-1:0] angle_y,
    output logic signed [OUT_ANG_W-1:0] smooth_x,
    output logic signed [OUT_ANG_W-1:0] smooth_y,
    input  adt_cmd_t                    cmd,
    output adt_sts_t                    sts
);

    // Point width: wide enough for an input coordinate and for half_res.
    localparam int PT_W  = (COORD_BITS > HALF_W) ? COORD_BITS : HALF_W;
    localparam int ANG_W = FRAC_BITS + 8;
    localparam int MUL_W = PT_W + 7;
    localparam int DIV_W = MUL_W + FRAC_BITS;
    localparam logic [DIV_W-1:0] LIM_Q =
        DIV_W'(ANGLE_DEG_LIM * (2 ** FRAC_BITS));
    localparam logic signed [ANG_W-1:0] NONE_ANG =
        ANG_W'(-(ANGLE_DEG_NONE * (2 ** FRAC_BITS)));

    // Configuration.
    logic [HALF_W-1:0]  half_reg;
    logic [DZ_LO_W-1:0] dz_lo_reg;
    logic [DZ_HI_W-1:0] dz_hi_reg;
    logic [DROP_W-1:0]  drop_min_reg, drop_max_reg;
    logic [TOL_W-1:0]   tol_y_reg, tol_x_reg;
    logic [SDIV_W-1:0]  sdiv_reg;

    // Captured request.
    logic                  found_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg;

    // Stroke state.
    logic            run_open_reg, run_open_next;
    logic            rising_reg, rising_next;
    logic [PT_W-1:0] start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic [PT_W-1:0] last_x_reg, last_x_next, last_y_reg, last_y_next;

    // Per-item working values.
    logic                    fired_w_reg, fired_w_next;
    logic [PT_W-1:0]         ax_reg, ax_next, ay_reg, ay_next;
    logic signed [ANG_W-1:0] ang_x_reg, ang_y_reg;
    logic signed [ANG_W-1:0] avg_x_reg, avg_y_reg;
    logic                    neg_reg;

    // Result register.
    logic                        fired_reg;
    logic [COORD_BITS-1:0]       aim_x_reg, aim_y_reg;
    logic signed [OUT_ANG_W-1:0] angle_x_reg, angle_y_reg;
    logic signed [OUT_ANG_W-1:0] smooth_x_reg, smooth_y_reg;

    // Stroke logic signals.
    logic [PT_W:0]          px_ext, py_ext, lo_ext, hi_ext;
    logic                   in_dz;
    logic [PT_W-1:0]        sx, sy;
    logic signed [PT_W+1:0] dy, dx, dy_abs, dx_abs;

    // Division operand signals.
    logic [PT_W-1:0]         aim_sel;
    logic signed [PT_W:0]    diff;
    logic [PT_W-1:0]         diff_mag;
    logic [MUL_W-1:0]        mag90;
    logic signed [ANG_W-1:0] tgt_sel, avg_sel;
    logic signed [ANG_W:0]   sdiff;
    logic [ANG_W:0]          sdiff_mag;
    logic                    op_neg;
    logic [DIV_W-1:0]        dividend;
    logic [DSOR_W-1:0]       divisor;
    logic                    div_done;
    logic [DIV_W-1:0]        quotient;

    // Division result signals.
    logic [DIV_W-1:0]        q_sat;
    logic signed [ANG_W-1:0] ang_mag, ang_res;
    logic signed [ANG_W:0]   step, avg_sum;
    logic signed [ANG_W-1:0] avg_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg     <= HALF_RES_RST;
            dz_lo_reg    <= DEAD_ZONE_LO_RST;
            dz_hi_reg    <= DEAD_ZONE_HI_RST;
            drop_min_reg <= DROP_MIN_RST;
            drop_max_reg <= DROP_MAX_RST;
            tol_y_reg    <= RETURN_Y_TOL_RST;
            tol_x_reg    <= RETURN_X_TOL_RST;
            sdiv_reg     <= SMOOTH_DIV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_RES:     half_reg     <= cfg_data[HALF_W-1:0];
                CFG_DEAD_ZONE_LO: dz_lo_reg    <= cfg_data[DZ_LO_W-1:0];
                CFG_DEAD_ZONE_HI: dz_hi_reg    <= cfg_data[DZ_HI_W-1:0];
                CFG_DROP_MIN:     drop_min_reg <= cfg_data[DROP_W-1:0];
                CFG_DROP_MAX:     drop_max_reg <= cfg_data[DROP_W-1:0];
                CFG_RETURN_Y_TOL: tol_y_reg    <= cfg_data[TOL_W-1:0];
                CFG_RETURN_X_TOL: tol_x_reg    <= cfg_data[TOL_W-1:0];
                CFG_SMOOTH_DIV:   sdiv_reg     <= cfg_data[SDIV_W-1:0];
                default:          ;
            endcase
        end
    end

    // Dead zone snap and stroke tracking.
    always_comb
    begin
        px_ext = (PT_W+1)'(px_reg);
        py_ext = (PT_W+1)'(py_reg);
        lo_ext = (PT_W+1)'(dz_lo_reg);
        hi_ext = (PT_W+1)'(dz_hi_reg);
        in_dz  = (px_ext >= lo_ext) && (px_ext < hi_ext) &&
                 (py_ext >= lo_ext) && (py_ext < hi_ext);
        sx = in_dz ? PT_W'(half_reg) : PT_W'(px_reg);
        sy = in_dz ? PT_W'(half_reg) : PT_W'(py_reg);

        dy     = $signed({2'b00, start_y_reg}) - $signed({2'b00, last_y_reg});
        dx     = $signed({2'b00, start_x_reg}) - $signed({2'b00, last_x_reg});
        dy_abs = (dy < 0) ? -dy : dy;
        dx_abs = (dx < 0) ? -dx : dx;

        run_open_next = run_open_reg;
        rising_next   = rising_reg;
        start_x_next  = start_x_reg;
        start_y_next  = start_y_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        fired_w_next  = 1'b0;
        ax_next       = sx;
        ay_next       = sy;

        if (!run_open_reg)
        begin
            start_x_next  = sx;
            start_y_next  = sy;
            last_x_next   = sx;
            last_y_next   = sy;
            run_open_next = 1'b1;
        end
        else if (rising_reg)
        begin
            if (sy <= last_y_reg)
            begin
                last_x_next = sx;
                last_y_next = sy;
            end
            else if ((dy >= $signed((PT_W+2)'(drop_min_reg))) &&
                     (dy <= $signed((PT_W+2)'(drop_max_reg))))
            begin
                rising_next = 1'b0;
            end
            else
            begin
                run_open_next = 1'b0;
            end
        end
        else
        begin
            if (sy >= last_y_reg)
            begin
                last_x_next = sx;
                last_y_next = sy;
            end
            else
            begin
                // The stroke ends here, fired or not.
                if ((dy_abs <= $signed((PT_W+2)'(tol_y_reg))) &&
                    (dx_abs <= $signed((PT_W+2)'(tol_x_reg))))
                begin
                    fired_w_next = 1'b1;
                    ax_next      = start_x_reg;
                    ay_next      = start_y_reg;
                end
                rising_next   = 1'b1;
                run_open_next = 1'b0;
            end
        end
    end

    // Divider operands. Angles divide |aim - half| * 90 * 2^FRAC_BITS by
    // half_res; smoothing divides |angle - avg| by smooth_div.
    always_comb
    begin
        aim_sel   = (cmd.op == OP_AX) ? ax_reg : ay_reg;
        diff      = $signed({1'b0, aim_sel}) - $signed((PT_W+1)'(half_reg));
        diff_mag  = (diff < 0) ? PT_W'(-diff) : PT_W'(diff);
        mag90     = MUL_W'(diff_mag) * MUL_W'(ANGLE_DEG_LIM);
        tgt_sel   = (cmd.op == OP_SX) ? ang_x_reg : ang_y_reg;
        avg_sel   = (cmd.op == OP_SX) ? avg_x_reg : avg_y_reg;
        sdiff     = (ANG_W+1)'(tgt_sel) - (ANG_W+1)'(avg_sel);
        sdiff_mag = (sdiff < 0) ? (ANG_W+1)'(-sdiff) : (ANG_W+1)'(sdiff);
        case (cmd.op)
            OP_AX, OP_AY:
            begin
                op_neg   = (diff < 0);
                dividend = {mag90, {FRAC_BITS{1'b0}}};
                divisor  = (half_reg == '0) ? DSOR_W'(1) : DSOR_W'(half_reg);
            end
            default:
            begin
                op_neg   = (sdiff < 0);
                dividend = DIV_W'(sdiff_mag);
                divisor  = (sdiv_reg == '0) ? DSOR_W'(1) : DSOR_W'(sdiv_reg);
            end
        endcase
    end

    adt_div
    #(
        .DIV_W (DIV_W),
        .DV_W  (DSOR_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Quotient back to a signed angle, or to a new running average.
    always_comb
    begin
        q_sat   = (quotient > LIM_Q) ? LIM_Q : quotient;
        ang_mag = ANG_W'(q_sat);
        ang_res = neg_reg ? -ang_mag : ang_mag;
        step    = neg_reg ? -$signed(quotient[ANG_W:0]) : $signed(quotient[ANG_W:0]);
        avg_sum = (ANG_W+1)'(avg_sel) + step;
        avg_res = ANG_W'(avg_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            rising_reg   <= 1'b1;
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            avg_x_reg    <= '0;
            avg_y_reg    <= '0;
        end
        else
        begin
            if (cmd.stroke)
            begin
                run_open_reg <= run_open_next;
                rising_reg   <= rising_next;
                start_x_reg  <= start_x_next;
                start_y_reg  <= start_y_next;
                last_x_reg   <= last_x_next;
                last_y_reg   <= last_y_next;
            end
            if (cmd.div_store && (cmd.op == OP_SX))
            begin
                avg_x_reg <= avg_res;
            end
            if (cmd.div_store && (cmd.op == OP_SY))
            begin
                avg_y_reg <= avg_res;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            found_reg <= found;
            px_reg    <= point_x;
            py_reg    <= point_y;
        end
        if (cmd.stroke)
        begin
            fired_w_reg <= fired_w_next;
            ax_reg      <= ax_next;
            ay_reg      <= ay_next;
        end
        if (cmd.div_start)
        begin
            neg_reg <= op_neg;
        end
        if (cmd.div_store && (cmd.op == OP_AX))
        begin
            ang_x_reg <= ang_res;
        end
        if (cmd.div_store && (cmd.op == OP_AY))
        begin
            ang_y_reg <= ang_res;
        end
        if (cmd.publish)
        begin
            smooth_x_reg <= OUT_ANG_W'(avg_x_reg);
            smooth_y_reg <= OUT_ANG_W'(avg_y_reg);
            if (found_reg)
            begin
                fired_reg   <= fired_w_reg;
                aim_x_reg   <= ax_reg[COORD_BITS-1:0];
                aim_y_reg   <= ay_reg[COORD_BITS-1:0];
                angle_x_reg <= OUT_ANG_W'(ang_x_reg);
                angle_y_reg <= OUT_ANG_W'(ang_y_reg);
            end
            else
            begin
                fired_reg   <= 1'b0;
                aim_x_reg   <= COORD_BITS'(PT_W'(half_reg));
                aim_y_reg   <= COORD_BITS'(PT_W'(half_reg));
                angle_x_reg <= OUT_ANG_W'(NONE_ANG);
                angle_y_reg <= OUT_ANG_W'(NONE_ANG);
            end
        end
    end

    assign sts.found    = found_reg;
    assign sts.div_done = div_done;

    assign fired    = fired_reg;
    assign aim_x    = aim_x_reg;
    assign aim_y    = aim_y_reg;
    assign angle_x  = angle_x_reg;
    assign angle_y  = angle_y_reg;
    assign smooth_x = smooth_x_reg;
    assign smooth_y = smooth_y_reg;

endmodule

/* sim/aim_dip_trigger_detector_tb.sv */
// ============================================================================
// aim_dip_trigger_detector_tb
// Self-checking bench for the aim dip trigger detector. It drives tracked
// points, missing-object frames and dip strokes, not all well-formed, under
// several register settings. Each result is predicted as its request is
// accepted and compared field by field. Both channels idle and stall at random.
// ============================================================================
module aim_dip_trigger_detector_tb;
    import adt_pkg::*;

    localparam int CW        = COORD_BITS_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int CMAX      = (1 << CW) - 1;
    localparam int RUN_LIMIT = 600000;

    typedef struct packed {
        logic          found;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } frame_t;

    typedef struct packed {
        logic                        fired;
        logic [CW-1:0]               aim_x;
        logic [CW-1:0]               aim_y;
        logic signed [OUT_ANG_W-1:0] angle_x;
        logic signed [OUT_ANG_W-1:0] angle_y;
        logic signed [OUT_ANG_W-1:0] smooth_x;
        logic signed [OUT_ANG_W-1:0] smooth_y;
    } aim_result_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index    = '0;
    logic [CFG_DATA_W-1:0]       cfg_data     = '0;
    logic                        item_valid   = 1'b0;
    logic                        item_stall;
    logic                        found        = 1'b0;
    logic [CW-1:0]               point_x      = '0;
    logic [CW-1:0]               point_y      = '0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic                        fired;
    logic [CW-1:0]               aim_x;
    logic [CW-1:0]               aim_y;
    logic signed [OUT_ANG_W-1:0] angle_x;
    logic signed [OUT_ANG_W-1:0] angle_y;
    logic signed [OUT_ANG_W-1:0] smooth_x;
    logic signed [OUT_ANG_W-1:0] smooth_y;

    // Register copies held by the predictor.
    int half_res_r = HALF_RES_RST;
    int dz_lo_r    = DEAD_ZONE_LO_RST;
    int dz_hi_r    = DEAD_ZONE_HI_RST;
    int drop_min_r = DROP_MIN_RST;
    int drop_max_r = DROP_MAX_RST;
    int tol_y_r    = RETURN_Y_TOL_RST;
    int tol_x_r    = RETURN_X_TOL_RST;
    int sdiv_r     = SMOOTH_DIV_RST;

    // Stroke state and averages of the predictor.
    bit     stroke_open = 1'b0;
    bit     rising      = 1'b1;
    int     start_x     = 0;
    int     start_y     = 0;
    int     last_x      = 0;
    int     last_y      = 0;
    longint avg_x       = 0;
    longint avg_y       = 0;

    frame_t      pending_frames[$];
    aim_result_t expected_results[$];

    frame_t      next_frame;
    frame_t      cur_frame;
    aim_result_t predicted;
    aim_result_t want;

    int frames_queued   = 0;
    int frames_sent     = 0;
    int results_seen    = 0;
    int fires_predicted = 0;
    int settings_used   = 0;
    int errors          = 0;
    int gap_pct         = 0;
    int stall_pct       = 0;
    int gap_left        = 0;
    int stall_left      = 0;
    int cycle_count     = 0;

    logic [CFG_IDX_W-1:0] reg_order[8] = '{CFG_HALF_RES, CFG_DEAD_ZONE_LO, CFG_DEAD_ZONE_HI,
                                            CFG_DROP_MIN, CFG_DROP_MAX, CFG_RETURN_Y_TOL,
                                            CFG_RETURN_X_TOL, CFG_SMOOTH_DIV};

    aim_dip_trigger_detector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .found        (found),
        .point_x      (point_x),
        .point_y      (point_y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .fired        (fired),
        .aim_x        (aim_x),
        .aim_y        (aim_y),
        .angle_x      (angle_x),
        .angle_y      (angle_y),
        .smooth_x     (smooth_x),
        .smooth_y     (smooth_y)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint angle_of(int aim);
        longint lim;
        longint num;
        longint div;
        longint q;
        lim = longint'(ANGLE_DEG_LIM) << FB;
        num = (longint'(aim) - longint'(half_res_r)) * ANGLE_DEG_LIM * (longint'(1) << FB);
        div = (half_res_r == 0) ? 1 : half_res_r;
        q   = num / div;
        if (q > lim)
        begin
            q = lim;
        end
        if (q < -lim)
        begin
            q = -lim;
        end
        return q;
    endfunction

    function automatic longint smooth_step(longint avg, longint target);
        longint d;
        d = (sdiv_r == 0) ? 1 : sdiv_r;
        return avg + (target - avg) / d;
    endfunction

    function automatic aim_result_t predict_frame(frame_t f);
        aim_result_t r;
        int          x;
        int          y;
        longint      ax;
        longint      ay;
        longint      dx;
        longint      dy;
        x       = f.x;
        y       = f.y;
        r.fired = 1'b0;
        if (!f.found)
        begin
            r.aim_x    = CW'(half_res_r);
            r.aim_y    = CW'(half_res_r);
            r.angle_x  = OUT_ANG_W'(-(longint'(ANGLE_DEG_NONE) << FB));
            r.angle_y  = OUT_ANG_W'(-(longint'(ANGLE_DEG_NONE) << FB));
            r.smooth_x = OUT_ANG_W'(avg_x);
            r.smooth_y = OUT_ANG_W'(avg_y);
            return r;
        end
        if (x >= dz_lo_r && x < dz_hi_r && y >= dz_lo_r && y < dz_hi_r)
        begin
            x = half_res_r;
            y = half_res_r;
        end
        if (!stroke_open)
        begin
            start_x     = x;
            start_y     = y;
            last_x      = x;
            last_y      = y;
            stroke_open = 1'b1;
        end
        else if (rising)
        begin
            if (y <= last_y)
            begin
                last_x = x;
                last_y = y;
            end
            else
            begin
                // The turning point itself is not recorded as part of the stroke.
                dy = start_y - last_y;
                if (dy >= drop_min_r && dy <= drop_max_r)
                begin
                    rising = 1'b0;
                end
                else
                begin
                    stroke_open = 1'b0;
                end
            end
        end
        else
        begin
            if (y >= last_y)
            begin
                last_x = x;
                last_y = y;
            end
            else
            begin
                dy = start_y - last_y;
                dx = start_x - last_x;
                if (dy < 0)
                begin
                    dy = -dy;
                end
                if (dx < 0)
                begin
                    dx = -dx;
                end
                if (dy <= tol_y_r && dx <= tol_x_r)
                begin
                    r.fired = 1'b1;
                    x       = start_x;
                    y       = start_y;
                end
                rising      = 1'b1;
                stroke_open = 1'b0;
            end
        end
        ax         = angle_of(x);
        ay         = angle_of(y);
        avg_y      = smooth_step(avg_y, ay);
        avg_x      = smooth_step(avg_x, ax);
        r.aim_x    = CW'(x);
        r.aim_y    = CW'(y);
        r.angle_x  = OUT_ANG_W'(ax);
        r.angle_y  = OUT_ANG_W'(ay);
        r.smooth_x = OUT_ANG_W'(avg_x);
        r.smooth_y = OUT_ANG_W'(avg_y);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int clamp_coord(int v);
        if (v < 0)
        begin
            return 0;
        end
        if (v > CMAX)
        begin
            return CMAX;
        end
        return v;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return CMAX;
            2:       return clamp_coord(dz_lo_r - int'($urandom_range(0, 1)));
            3:       return clamp_coord(dz_hi_r - int'($urandom_range(0, 1)));
            default: return $urandom_range(0, CMAX);
        endcase
    endfunction

    task automatic queue_frame(bit f, int x, int y);
        frame_t fr;
        fr.found = f;
        fr.x     = CW'(x);
        fr.y     = CW'(y);
        pending_frames = {pending_frames, fr};
        frames_queued++;
    endtask

    // A seen point, now and then preceded by a frame in which the object is lost.
    task automatic queue_seen(int x, int y);
        if ($urandom_range(0, 99) < 6)
        begin
            queue_frame(1'b0, $urandom_range(0, CMAX), $urandom_range(0, CMAX));
        end
        queue_frame(1'b1, clamp_coord(x), clamp_coord(y));
    endtask

    // One up-then-down stroke: fall from the start, climb back near it, then
    // a final fall that closes the stroke.
    task automatic queue_dip();
        int drop;
        int x0;
        int y0;
        int bottom;
        int xe;
        int ye;
        int n_fall;
        int n_back;
        if (drop_min_r <= drop_max_r && $urandom_range(0, 9) < 8)
        begin
            drop = $urandom_range(drop_max_r, drop_min_r);
        end
        else
        begin
            drop = $urandom_range(0, 400);
        end
        if (drop > CMAX)
        begin
            drop = CMAX;
        end
        y0     = $urandom_range(CMAX, drop);
        x0     = $urandom_range(0, CMAX);
        bottom = y0 - drop;
        n_fall = $urandom_range(1, 4);
        queue_seen(x0, y0);
        for (int k = 1; k <= n_fall; k++)
        begin
            queue_seen(x0 + int'($urandom_range(0, 6)) - 3, y0 - drop * k / n_fall);
        end
        ye = y0 + int'($urandom_range(0, 2 * tol_y_r + 8)) - tol_y_r - 4;
        xe = clamp_coord(x0 + int'($urandom_range(0, 2 * tol_x_r + 8)) - tol_x_r - 4);
        if (ye <= bottom)
        begin
            ye = bottom + 1;
        end
        ye     = clamp_coord(ye);
        n_back = $urandom_range(2, 5);
        for (int k = 1; k <= n_back; k++)
        begin
            queue_seen(xe, bottom + (ye - bottom) * k / n_back);
        end
        if (ye > 0)
        begin
            queue_seen(xe, $urandom_range(0, ye - 1));
        end
    endtask

    task automatic queue_mix(int n);
        int target;
        target = frames_queued + n;
        while (frames_queued < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                queue_dip();
            end
            else
            begin
                queue_frame($urandom_range(0, 3) != 0, pick_coord(), pick_coord());
            end
        end
    endtask

    task automatic wait_idle(int settle);
        wait (results_seen >= frames_queued);
        repeat (settle) @(posedge clk);
    endtask

    // Writes all eight registers back to back; only called while the block is idle.
    task automatic set_regs(int hr, int lo, int hi, int dmin, int dmax, int ty, int tx, int sd);
        int vals[8];
        vals = '{hr, lo, hi, dmin, dmax, ty, tx, sd};
        for (int i = 0; i < 8; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= reg_order[i];
            cfg_data  <= CFG_DATA_W'(vals[i]);
        end
        @(posedge clk);
        cfg_we     <= 1'b0;
        half_res_r = hr & ((1 << HALF_W) - 1);
        dz_lo_r    = lo & ((1 << DZ_LO_W) - 1);
        dz_hi_r    = hi & ((1 << DZ_HI_W) - 1);
        drop_min_r = dmin & ((1 << DROP_W) - 1);
        drop_max_r = dmax & ((1 << DROP_W) - 1);
        tol_y_r    = ty & ((1 << TOL_W) - 1);
        tol_x_r    = tx & ((1 << TOL_W) - 1);
        sdiv_r     = sd & ((1 << SDIV_W) - 1);
        settings_used++;
    endtask

    task automatic check_field(string name, logic signed [16:0] exp_v, logic signed [16:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: result %0d %s expected %0d got %0d",
                     $time, results_seen, name, exp_v, got_v);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                // The request is taken at this edge; predict against current state.
                cur_frame = {found, point_x, point_y};
                predicted = predict_frame(cur_frame);
                expected_results = {expected_results, predicted};
                if (predicted.fired)
                begin
                    fires_predicted++;
                end
                frames_sent++;
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    item_valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_frames.size() != 0 && $urandom_range(0, 99) < gap_pct)
                begin
                    item_valid <= 1'b0;
                    gap_left   = $urandom_range(0, 3);
                end
                else if (pending_frames.size() != 0)
                begin
                    next_frame = pending_frames.pop_front();
                    item_valid <= 1'b1;
                    found      <= next_frame.found;
                    point_x    <= next_frame.x;
                    point_y    <= next_frame.y;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result %0d arrived with nothing expected", $time, results_seen);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("fired", want.fired, fired);
                    check_field("aim_x", want.aim_x, aim_x);
                    check_field("aim_y", want.aim_y, aim_y);
                    check_field("angle_x", $signed(want.angle_x), $signed(angle_x));
                    check_field("angle_y", $signed(want.angle_y), $signed(angle_y));
                    check_field("smooth_x", $signed(want.smooth_x), $signed(smooth_x));
                    check_field("smooth_y", $signed(want.smooth_y), $signed(smooth_y));
                end
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                result_stall <= 1'b1;
                stall_left   = $urandom_range(0, 3);
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, frames_queued - results_seen);
            $display("aim_dip_trigger_detector_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults: lost object at the corners, the corners themselves,
        // dead zone edges, rises outside the window, a firing stroke with a lost
        // frame inside it and a stroke that returns too far from its start.
        queue_frame(1'b0, 0, 0);
        queue_frame(1'b0, CMAX, CMAX);
        queue_frame(1'b1, 0, 0);
        queue_frame(1'b1, CMAX, CMAX);
        queue_frame(1'b1, CMAX, 0);
        queue_frame(1'b1, 0, CMAX);
        queue_frame(1'b1, 230, 230);
        queue_frame(1'b1, 220, 259);
        queue_frame(1'b1, 260, 240);
        queue_frame(1'b1, 219, 219);
        queue_frame(1'b1, 219, 230);
        queue_frame(1'b1, 100, 400);
        queue_frame(1'b1, 100, 380);
        queue_frame(1'b0, 5, 5);
        queue_frame(1'b1, 100, 350);
        queue_frame(1'b1, 100, 360);
        queue_frame(1'b1, 100, 390);
        queue_frame(1'b1, 102, 398);
        queue_frame(1'b1, 102, 300);
        queue_frame(1'b1, 700, 500);
        queue_frame(1'b1, 700, 450);
        queue_frame(1'b1, 700, 460);
        queue_frame(1'b1, 700, 470);
        queue_frame(1'b1, 700, 460);
        queue_frame(1'b1, 800, 1000);
        queue_frame(1'b1, 800, 700);
        queue_frame(1'b1, 800, 710);
        wait_idle(8);

        gap_pct   = 20;
        stall_pct = 20;
        queue_mix(100);
        wait_idle(8);

        gap_pct   = 10;
        stall_pct = 40;
        set_regs(512, 500, 524, 10, 300, 40, 40, 1);
        queue_mix(120);
        wait_idle(8);

        // The dead zone covers the whole plane, so every point snaps to centre.
        gap_pct   = 30;
        stall_pct = 5;
        set_regs(1, 0, 1024, 0, 1023, 0, 0, 255);
        queue_mix(40);
        wait_idle(8);

        // Zero centre and zero divisor, an empty dead zone, widest tolerances.
        gap_pct   = 0;
        stall_pct = 25;
        set_regs(0, 1023, 0, 1023, 1023, 1023, 1023, 0);
        queue_mix(60);
        wait_idle(8);

        gap_pct   = 25;
        stall_pct = 0;
        set_regs(1023, 100, 200, 16, 64, 8, 8, 2);
        queue_mix(70);
        wait_idle(8);

        for (int p = 0; p < 3; p++)
        begin
            gap_pct   = $urandom_range(0, 30);
            stall_pct = $urandom_range(0, 30);
            set_regs($urandom_range(1, 512), $urandom_range(0, 1023), $urandom_range(0, 1024),
                     $urandom_range(0, 100), $urandom_range(100, 400), $urandom_range(0, 64),
                     $urandom_range(0, 64), $urandom_range(1, 255));
            queue_mix(90);
            wait_idle(8);
        end

        // Closing stretch back at the defaults with no idling on either side.
        gap_pct   = 0;
        stall_pct = 0;
        set_regs(HALF_RES_RST, DEAD_ZONE_LO_RST, DEAD_ZONE_HI_RST, DROP_MIN_RST,
                 DROP_MAX_RST, RETURN_Y_TOL_RST, RETURN_X_TOL_RST, SMOOTH_DIV_RST);
        queue_mix(90);
        wait_idle(150);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            errors++;
        end
        $display("Sent %0d frames under %0d register settings; %0d strokes fired.",
                 frames_sent, settings_used + 1, fires_predicted);
        $display("Compared %0d results, %0d mismatches.", results_seen, errors);
        if (errors == 0)
        begin
            $display("aim_dip_trigger_detector_tb: done, clean");
        end
        else
        begin
            $display("aim_dip_trigger_detector_tb: done, errors");
        end
        $finish;
    end

endmodule
